// ===== rtl/core/round_robin_task_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler: assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Sizes, operation codes, result codes and task state codes.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Table size and id width.
  localparam int MAX_TASKS = 16;
  localparam int ID_WIDTH  = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

  // Operation codes carried by in_func; the two top codes do nothing.
  typedef enum logic [2:0] {
    FUNC_CREATE  = 3'd0,
    FUNC_BLOCK   = 3'd1,
    FUNC_READY   = 3'd2,
    FUNC_KILL    = 3'd3,
    FUNC_YIELD   = 3'd4,
    FUNC_COLLECT = 3'd5
  } func_t;

  // Result codes carried by out_status.
  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2,
    RES_EXHAUSTED = 2'd3
  } res_t;

  // Per-task state codes held in the table.
  typedef enum logic [1:0] {
    TS_READY   = 2'd0,
    TS_RUNNING = 2'd1,
    TS_BLOCKED = 2'd2,
    TS_DEAD    = 2'd3
  } task_st_t;

endpackage

// ===== rtl/core/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Task table with create, block, ready, kill, yield and collect requests.
// A small sequencer walks the table one slot per cycle through a single
// read port, collecting lookup, free-slot and yield-candidate results.
//
//   channel  direction  fields                               handshake
//   in_      input      func, task_id                        in_valid/in_ready
//   out_     output     status, new_id, running_id           out_valid/out_ready
//
// Each request walks the whole table; a yield that hands over from a running
// task adds a fixup step, and the result then waits until it is taken.
// The walk reads the table memory one slot per cycle.
// Reset (rst_n low, synchronous) empties the table, clears the running task
// and sets the next id to 1. Table contents are not cleared: the used bits
// guard them. A new request is taken only once the result has been taken.
// ----------------------------------------------------------------------------
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_func,
  input  logic [rrts_pkg::ID_WIDTH-1:0]  in_task_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [rrts_pkg::ID_WIDTH-1:0]  out_new_id,
  output logic signed [rrts_pkg::ID_WIDTH:0] out_running_id
);

  import rrts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_COMMIT = 5'b00100,
    S_FIXUP  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  // Table memories: id and state per slot, one write and one read per cycle.
  logic [ID_WIDTH-1:0] id_mem [MAX_TASKS];
  task_st_t            st_mem [MAX_TASKS];

  state_t              state_r, state_nxt;
  logic [2:0]          req_func_r, req_func_nxt;
  logic [ID_WIDTH-1:0] req_id_r, req_id_nxt;

  logic [SLOT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0]   rd_idx_r;
  logic [ID_WIDTH-1:0] rd_id_r;
  task_st_t            rd_st_r;

  logic                free_fnd_r, free_fnd_nxt;
  logic [SLOT_W-1:0]   free_slot_r, free_slot_nxt;
  logic                any_used_r, any_used_nxt;
  logic                hit_r, hit_nxt;
  logic [SLOT_W-1:0]   hit_slot_r, hit_slot_nxt;
  task_st_t            cur_st_r, cur_st_nxt;
  logic                first_fnd_r, first_fnd_nxt;
  logic [SLOT_W-1:0]   first_slot_r, first_slot_nxt;
  logic [ID_WIDTH-1:0] first_id_r, first_id_nxt;
  logic                after_fnd_r, after_fnd_nxt;
  logic [SLOT_W-1:0]   after_slot_r, after_slot_nxt;
  logic [ID_WIDTH-1:0] after_id_r, after_id_nxt;
  logic [SLOT_W-1:0]   fix_slot_r, fix_slot_nxt;

  logic [MAX_TASKS-1:0] slot_used_r, slot_used_nxt;
  logic                running_valid_r, running_valid_nxt;
  logic [SLOT_W-1:0]   running_slot_r, running_slot_nxt;
  logic [ID_WIDTH-1:0] run_id_r, run_id_nxt;
  logic [ID_WIDTH:0]   id_counter_r, id_counter_nxt;

  logic [1:0]          out_status_r, out_status_nxt;
  logic [ID_WIDTH-1:0] out_new_id_r, out_new_id_nxt;

  logic                id_we;
  logic [SLOT_W-1:0]   id_waddr;
  logic [ID_WIDTH-1:0] id_wdata;
  logic                st_we;
  logic [SLOT_W-1:0]   st_waddr;
  task_st_t            st_wdata;

  logic                rd_used;
  logic                rd_cand;
  logic                pick_fnd;
  logic [SLOT_W-1:0]   pick_slot;
  logic [ID_WIDTH-1:0] pick_id;

  // Handshake and result ports.
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_RESP);
  assign out_status = out_status_r;
  assign out_new_id = out_new_id_r;
  assign out_running_id = (running_valid_r && slot_used_r[running_slot_r]) ?
                          {1'b0, run_id_r} : '1;

  // Per-slot decode of the returned read data.
  assign rd_used = slot_used_r[rd_idx_r];
  assign rd_cand = rd_used && (rd_st_r == TS_READY) &&
                   !(running_valid_r && (rd_idx_r == running_slot_r));

  // Yield choice: the next ready id after the current one, else the smallest.
  assign pick_fnd  = after_fnd_r || first_fnd_r;
  assign pick_slot = after_fnd_r ? after_slot_r : first_slot_r;
  assign pick_id   = after_fnd_r ? after_id_r : first_id_r;

  // Sequencer and table update.
  always_comb begin
    state_nxt         = state_r;
    req_func_nxt      = req_func_r;
    req_id_nxt        = req_id_r;
    scan_idx_nxt      = scan_idx_r;
    issue_done_nxt    = issue_done_r;
    rd_vld_nxt        = 1'b0;
    free_fnd_nxt      = free_fnd_r;
    free_slot_nxt     = free_slot_r;
    any_used_nxt      = any_used_r;
    hit_nxt           = hit_r;
    hit_slot_nxt      = hit_slot_r;
    cur_st_nxt        = cur_st_r;
    first_fnd_nxt     = first_fnd_r;
    first_slot_nxt    = first_slot_r;
    first_id_nxt      = first_id_r;
    after_fnd_nxt     = after_fnd_r;
    after_slot_nxt    = after_slot_r;
    after_id_nxt      = after_id_r;
    fix_slot_nxt      = fix_slot_r;
    slot_used_nxt     = slot_used_r;
    running_valid_nxt = running_valid_r;
    running_slot_nxt  = running_slot_r;
    run_id_nxt        = run_id_r;
    id_counter_nxt    = id_counter_r;
    out_status_nxt    = out_status_r;
    out_new_id_nxt    = out_new_id_r;
    id_we             = 1'b0;
    id_waddr          = free_slot_r;
    id_wdata          = id_counter_r[ID_WIDTH-1:0];
    st_we             = 1'b0;
    st_waddr          = hit_slot_r;
    st_wdata          = TS_READY;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_func_nxt   = in_func;
          req_id_nxt     = in_task_id;
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          free_fnd_nxt   = 1'b0;
          any_used_nxt   = 1'b0;
          hit_nxt        = 1'b0;
          first_fnd_nxt  = 1'b0;
          after_fnd_nxt  = 1'b0;
          cur_st_nxt     = TS_READY;
          out_status_nxt = RES_OK;
          out_new_id_nxt = '0;
          state_nxt      = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle until the last slot has been addressed.
        if (!issue_done_r) begin
          rd_vld_nxt     = 1'b1;
          scan_idx_nxt   = scan_idx_r + 1'b1;
          issue_done_nxt = (scan_idx_r == LAST_SLOT);
        end
        // Fold the slot read in the previous cycle into the running results.
        if (rd_vld_r) begin
          if (!rd_used && !free_fnd_r) begin
            free_fnd_nxt  = 1'b1;
            free_slot_nxt = rd_idx_r;
          end
          if (rd_used) begin
            any_used_nxt = 1'b1;
          end
          if (rd_used && !hit_r && (rd_id_r == req_id_r)) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = rd_idx_r;
          end
          if (rd_idx_r == running_slot_r) begin
            cur_st_nxt = rd_st_r;
          end
          if (rd_cand && (!first_fnd_r || (rd_id_r < first_id_r))) begin
            first_fnd_nxt  = 1'b1;
            first_slot_nxt = rd_idx_r;
            first_id_nxt   = rd_id_r;
          end
          if (rd_cand && running_valid_r && (rd_id_r > run_id_r) &&
              (!after_fnd_r || (rd_id_r < after_id_r))) begin
            after_fnd_nxt  = 1'b1;
            after_slot_nxt = rd_idx_r;
            after_id_nxt   = rd_id_r;
          end
          // Collect frees dead slots as the walk passes them.
          if ((req_func_r == FUNC_COLLECT) && rd_used && (rd_st_r == TS_DEAD)) begin
            slot_used_nxt[rd_idx_r] = 1'b0;
            if (running_valid_r && (running_slot_r == rd_idx_r)) begin
              running_valid_nxt = 1'b0;
            end
          end
          if (rd_idx_r == LAST_SLOT) begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        state_nxt = S_RESP;
        case (req_func_r)
          FUNC_CREATE: begin
            if (!free_fnd_r) begin
              out_status_nxt = RES_FULL;
            end else if (id_counter_r[ID_WIDTH]) begin
              out_status_nxt = RES_EXHAUSTED;
            end else begin
              id_we    = 1'b1;
              id_waddr = free_slot_r;
              id_wdata = id_counter_r[ID_WIDTH-1:0];
              st_we    = 1'b1;
              st_waddr = free_slot_r;
              st_wdata = any_used_r ? TS_READY : TS_RUNNING;
              slot_used_nxt[free_slot_r] = 1'b1;
              out_new_id_nxt = id_counter_r[ID_WIDTH-1:0];
              id_counter_nxt = id_counter_r + 1'b1;
              if (!any_used_r) begin
                running_valid_nxt = 1'b1;
                running_slot_nxt  = free_slot_r;
                run_id_nxt        = id_counter_r[ID_WIDTH-1:0];
              end
            end
          end

          FUNC_BLOCK, FUNC_READY, FUNC_KILL: begin
            if (!hit_r) begin
              out_status_nxt = RES_NOT_FOUND;
            end else begin
              st_we    = 1'b1;
              st_waddr = hit_slot_r;
              if (req_func_r == FUNC_BLOCK) begin
                st_wdata = TS_BLOCKED;
                if (running_valid_r && (running_slot_r == hit_slot_r)) begin
                  running_valid_nxt = 1'b0;
                end
              end else if (req_func_r == FUNC_READY) begin
                st_wdata = TS_READY;
              end else begin
                st_wdata = TS_DEAD;
              end
            end
          end

          FUNC_YIELD: begin
            if (pick_fnd) begin
              st_we             = 1'b1;
              st_waddr          = pick_slot;
              st_wdata          = TS_RUNNING;
              running_valid_nxt = 1'b1;
              running_slot_nxt  = pick_slot;
              run_id_nxt        = pick_id;
              fix_slot_nxt      = running_slot_r;
              // The previous running task steps back to ready.
              if (running_valid_r && (cur_st_r == TS_RUNNING)) begin
                state_nxt = S_FIXUP;
              end
            end else if (running_valid_r &&
                         ((cur_st_r == TS_RUNNING) || (cur_st_r == TS_READY))) begin
              st_we    = 1'b1;
              st_waddr = running_slot_r;
              st_wdata = TS_RUNNING;
            end
          end

          default: begin
          end
        endcase
      end

      S_FIXUP: begin
        st_we     = 1'b1;
        st_waddr  = fix_slot_r;
        st_wdata  = TS_READY;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      issue_done_r    <= 1'b0;
      rd_vld_r        <= 1'b0;
      slot_used_r     <= '0;
      running_valid_r <= 1'b0;
      running_slot_r  <= '0;
      id_counter_r    <= (ID_WIDTH + 1)'(1);
    end else begin
      state_r         <= state_nxt;
      issue_done_r    <= issue_done_nxt;
      rd_vld_r        <= rd_vld_nxt;
      slot_used_r     <= slot_used_nxt;
      running_valid_r <= running_valid_nxt;
      running_slot_r  <= running_slot_nxt;
      id_counter_r    <= id_counter_nxt;
    end
  end

  // Request, walk results and result payload.
  always_ff @(posedge clk) begin
    req_func_r   <= req_func_nxt;
    req_id_r     <= req_id_nxt;
    scan_idx_r   <= scan_idx_nxt;
    free_fnd_r   <= free_fnd_nxt;
    free_slot_r  <= free_slot_nxt;
    any_used_r   <= any_used_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    cur_st_r     <= cur_st_nxt;
    first_fnd_r  <= first_fnd_nxt;
    first_slot_r <= first_slot_nxt;
    first_id_r   <= first_id_nxt;
    after_fnd_r  <= after_fnd_nxt;
    after_slot_r <= after_slot_nxt;
    after_id_r   <= after_id_nxt;
    fix_slot_r   <= fix_slot_nxt;
    run_id_r     <= run_id_nxt;
    out_status_r <= out_status_nxt;
    out_new_id_r <= out_new_id_nxt;
  end

  // Table memories: registered read at the walk address, single write port.
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
    rd_id_r  <= id_mem[scan_idx_r];
    rd_st_r  <= st_mem[scan_idx_r];
    if (id_we) begin
      id_mem[id_waddr] <= id_wdata;
    end
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
  end

  // Checks on the sequencer and the running-task bookkeeping.
  `RRTS_ASSERT_SAME(a_no_overlap, out_valid, !in_ready, "request taken while a result waits")
  `RRTS_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_r == S_SCAN, "accepted request did not start a walk")
  `RRTS_ASSERT_SAME(a_run_used, (state_r == S_IDLE) && running_valid_r, slot_used_r[running_slot_r], "running task is not in the table")
  `RRTS_ASSERT_SAME(a_id_limit, 1'b1, id_counter_r <= {1'b1, {ID_WIDTH{1'b0}}}, "id counter ran past the last id")
  `RRTS_ASSERT_NEXT(a_result_done, out_valid && out_ready, in_ready, "scheduler did not return to idle after a result")

endmodule
